[src/dtf_pkg.sv]
// Shared types and constants for the decimal text to 16.16 fixed-point converter.
// Used by dtf_ctrl, dtf_datapath and decimal_text_to_fixed16_core; no dependencies.
package dtf_pkg;

    localparam int MAX_FRACTION_DIGITS = 6;

    localparam int CHAR_W   = 8;
    localparam int INT_W    = 16;
    localparam int VAL_W    = 32;
    localparam int RATE_W   = 10;
    localparam int CFG_W    = 10;
    localparam int FRAC_SHIFT = 16;

    // Fraction accumulator and divisor share one width: 10^n is never a power of two.
    localparam longint FRAC_LIMIT = 10 ** MAX_FRACTION_DIGITS;
    localparam int FRAC_W  = $clog2(FRAC_LIMIT);
    localparam int CNT_W   = $clog2(MAX_FRACTION_DIGITS + 1);
    // The rounded fraction can reach 65536, so the quotient needs one extra bit.
    localparam int QUO_W   = FRAC_SHIFT + 1;
    localparam int DIV_W   = FRAC_W + QUO_W;
    localparam int STEP_W  = $clog2(QUO_W);
    localparam int PROD_W  = VAL_W + RATE_W + 1;
    localparam int TICK_W  = VAL_W + FRAC_SHIFT;

    // Configuration register indexes.
    localparam logic REG_TICK_MODE = 1'b0;
    localparam logic REG_TICK_RATE = 1'b1;

    localparam logic [RATE_W-1:0] TICK_RATE_RESET = RATE_W'(62);

    typedef struct packed {
        logic scan;   // take one character of the request
        logic prep;   // load the rounding division
        logic step;   // one restoring division step
        logic build;  // form the signed 16.16 value
        logic mul;    // multiply by the tick rate
        logic emit;   // load the output register and clear the scan
    } dtf_cmd_t;

    typedef struct packed {
        logic frac_none;  // no fraction digits, division can be skipped
        logic tick_mode;
    } dtf_stat_t;

    function automatic logic [FRAC_W-1:0] pow10(input int unsigned n);
        logic [FRAC_W-1:0] r;
        case (n)
            0:       r = FRAC_W'(64'd1);
            1:       r = FRAC_W'(64'd10);
            2:       r = FRAC_W'(64'd100);
            3:       r = FRAC_W'(64'd1000);
            4:       r = FRAC_W'(64'd10000);
            5:       r = FRAC_W'(64'd100000);
            6:       r = FRAC_W'(64'd1000000);
            7:       r = FRAC_W'(64'd10000000);
            8:       r = FRAC_W'(64'd100000000);
            9:       r = FRAC_W'(64'd1000000000);
            default: r = FRAC_W'(64'd1);
        endcase
        return r;
    endfunction

endpackage

[src/decimal_text_to_fixed16_core.sv]
// Top level of the decimal text to signed 16.16 fixed-point converter.
// Depends on dtf_pkg, dtf_ctrl and dtf_datapath.
//
//   Channel   Handshake           Payload
//   -------   -----------------   ---------------------------------
//   input     s_valid / s_ready   s_char_code[7:0], s_last_char
//   result    m_valid / m_ready   m_result_value[31:0] (signed)
//   config    cfg_wr_en           cfg_index, cfg_wr_data[9:0]
//
// Characters are taken while the controller is in its scan state. After the scan of a
// last character come the divider load, the bit-serial rounding division (skipped
// when there are no fraction digits), forming the value, the tick multiply in tick
// mode only, and the load of the output register.
// Reset is synchronous and active low; it restores tick_rate to 62 and clears the scan.
// A stalled result holds in the output register while the next request is scanned.
module decimal_text_to_fixed16_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [dtf_pkg::CHAR_W-1:0]       s_char_code,
    input  logic                             s_last_char,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [dtf_pkg::VAL_W-1:0] m_result_value,
    input  logic                             cfg_wr_en,
    input  logic                             cfg_index,
    input  logic [dtf_pkg::CFG_W-1:0]        cfg_wr_data
);
    import dtf_pkg::*;

    dtf_cmd_t  cmd;
    dtf_stat_t stat;

    dtf_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    dtf_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_char_code    (s_char_code),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .cmd            (cmd),
        .stat           (stat),
        .m_result_value (m_result_value)
    );

endmodule

[src/dtf_ctrl.sv]
// Controller state machine for the decimal text converter.
// Depends on dtf_pkg; drives the commands of dtf_datapath and the handshake flags.
module dtf_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_last_char,
    output logic               m_valid,
    input  logic               m_ready,
    input  dtf_pkg::dtf_stat_t stat,
    output dtf_pkg::dtf_cmd_t  cmd
);
    import dtf_pkg::*;

    localparam logic [2:0] S_SCAN = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_VAL  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              accept;
    logic              out_free;

    assign s_ready  = (state_reg == S_SCAN);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            S_SCAN: begin
                cmd.scan = accept;
                if (accept && s_last_char) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep  = 1'b1;
                step_next = '0;
                state_next = stat.frac_none ? S_VAL : S_DIV;
            end
            S_DIV: begin
                cmd.step  = 1'b1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(QUO_W - 1)) begin
                    state_next = S_VAL;
                end
            end
            S_VAL: begin
                cmd.build  = 1'b1;
                state_next = stat.tick_mode ? S_MUL : S_OUT;
            end
            S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.emit     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            default: begin
                state_next = S_SCAN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SCAN;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[src/dtf_datapath.sv]
// Datapath of the decimal text converter: character scan, restoring divider,
// value assembly, tick multiply and output register. Depends on dtf_pkg.
module dtf_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [dtf_pkg::CHAR_W-1:0]  s_char_code,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_index,
    input  logic [dtf_pkg::CFG_W-1:0]   cfg_wr_data,
    input  dtf_pkg::dtf_cmd_t           cmd,
    output dtf_pkg::dtf_stat_t          stat,
    output logic signed [dtf_pkg::VAL_W-1:0] m_result_value
);
    import dtf_pkg::*;

    localparam logic [1:0] PH_SIGN = 2'd0;
    localparam logic [1:0] PH_INT  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;
    localparam logic [1:0] PH_END  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_PLUS  = CHAR_W'(8'h2B);
    localparam logic [CHAR_W-1:0] CH_MINUS = CHAR_W'(8'h2D);
    localparam logic [CHAR_W-1:0] CH_POINT = CHAR_W'(8'h2E);
    localparam logic [CHAR_W-1:0] CH_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CH_NINE  = CHAR_W'(8'h39);

    // Configuration registers.
    logic              mode_reg;
    logic [RATE_W-1:0] rate_reg;

    // Scan state.
    logic [1:0]        phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic [INT_W-1:0]  int_reg, int_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic [CNT_W-1:0]  fdig_reg, fdig_next;

    // Division, value and product.
    logic [FRAC_W-1:0] scale_reg;
    logic [DIV_W-1:0]  div_reg;
    logic signed [VAL_W-1:0]  val_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [VAL_W-1:0]  result_reg;

    logic              is_digit;
    logic [3:0]        digit;
    logic [1:0]        eff_phase;
    logic [FRAC_W-1:0] scale_sel;
    logic [DIV_W-1:0]  numerator;
    logic [FRAC_W:0]   trial;
    logic [FRAC_W:0]   diff;
    logic              fits;
    logic [FRAC_W-1:0] rem_next;
    logic [VAL_W-1:0]  val_sum;
    logic [TICK_W-1:0] tick_sum;

    assign is_digit = (s_char_code >= CH_ZERO) && (s_char_code <= CH_NINE);
    assign digit    = s_char_code[3:0];

    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fdig_next  = fdig_reg;
        eff_phase  = (phase_reg == PH_SIGN) ? PH_INT : phase_reg;
        if ((phase_reg == PH_SIGN) && (s_char_code == CH_PLUS || s_char_code == CH_MINUS)) begin
            phase_next = PH_INT;
            neg_next   = (s_char_code == CH_MINUS);
        end else begin
            phase_next = eff_phase;
            case (eff_phase)
                PH_INT: begin
                    if (is_digit) begin
                        int_next = (int_reg << 3) + (int_reg << 1) + INT_W'(digit);
                    end else if (s_char_code == CH_POINT) begin
                        phase_next = PH_FRAC;
                    end else begin
                        phase_next = PH_END;
                    end
                end
                PH_FRAC: begin
                    if (is_digit && (fdig_reg < CNT_W'(MAX_FRACTION_DIGITS))) begin
                        frac_next = (frac_reg << 3) + (frac_reg << 1) + FRAC_W'(digit);
                        fdig_next = fdig_reg + CNT_W'(1);
                    end else begin
                        phase_next = PH_END;
                    end
                end
                default: begin
                    phase_next = PH_END;
                end
            endcase
        end
    end

    // Rounding division: (frac * 65536 + scale / 2) / scale, one quotient bit a step.
    // The top FRAC_W bits of the numerator are below the divisor, so only the
    // quotient bits need steps.
    assign scale_sel = pow10(int'(fdig_reg));
    assign numerator = {1'b0, frac_reg, FRAC_SHIFT'(0)} + DIV_W'(scale_sel >> 1);
    assign trial     = {div_reg[DIV_W-1:QUO_W], div_reg[QUO_W-1]};
    assign diff      = trial - {1'b0, scale_reg};
    assign fits      = (trial >= {1'b0, scale_reg});
    assign rem_next  = fits ? diff[FRAC_W-1:0] : trial[FRAC_W-1:0];

    assign val_sum  = {int_reg, FRAC_SHIFT'(0)} + VAL_W'(div_reg[QUO_W-1:0]);
    assign tick_sum = TICK_W'(prod_reg) + TICK_W'(32'h8000);

    assign stat.frac_none = (fdig_reg == '0);
    assign stat.tick_mode = mode_reg;
    assign m_result_value = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= 1'b0;
            rate_reg  <= TICK_RATE_RESET;
            phase_reg <= PH_SIGN;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            fdig_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TICK_MODE: mode_reg <= cfg_wr_data[0];
                    REG_TICK_RATE: rate_reg <= cfg_wr_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                phase_reg <= PH_SIGN;
                neg_reg   <= 1'b0;
                int_reg   <= '0;
                frac_reg  <= '0;
                fdig_reg  <= '0;
            end else if (cmd.scan) begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                int_reg   <= int_next;
                frac_reg  <= frac_next;
                fdig_reg  <= fdig_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            scale_reg <= scale_sel;
            div_reg   <= (fdig_reg == '0) ? '0 : numerator;
        end else if (cmd.step) begin
            div_reg <= {rem_next, div_reg[QUO_W-2:0], fits};
        end
        if (cmd.build) begin
            val_reg <= neg_reg ? -val_sum : val_sum;
        end
        if (cmd.mul) begin
            prod_reg <= val_reg * $signed({1'b0, rate_reg});
        end
        if (cmd.emit) begin
            result_reg <= mode_reg ? tick_sum[TICK_W-1:FRAC_SHIFT] : val_reg;
        end
    end

endmodule
